@@ sv/smcv_pkg.sv @@
package smcv_pkg;

  // Field widths of one input item and one result item
  localparam int unsigned PixW   = 8;
  localparam int unsigned DispW  = 6;
  localparam int unsigned CostW  = 17;

  // Configuration register widths
  localparam int unsigned NumW   = 7;
  localparam int unsigned GainW  = 16;
  localparam int unsigned CapW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Product of a Q8.8 gain and an 8-bit difference
  localparam int unsigned ProdW  = GainW + PixW;

  // Upper bound on the cost the datapath can produce
  localparam logic [CostW-1:0] CostMax = 17'd130560;

  // Column counter saturation value
  localparam logic [NumW-1:0] ColMax = 7'd127;

  // Reset values of the configuration registers
  localparam logic [NumW-1:0]  NumDispRst   = 7'd64;
  localparam logic [GainW-1:0] DataGainRst  = 16'd256;
  localparam logic [CapW-1:0]  DataCapRst   = 8'd255;
  localparam logic [GainW-1:0] SeedGainRst  = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumDisp  = 2'd0,
    CfgDataGain = 2'd1,
    CfgDataCap  = 2'd2,
    CfgSeedGain = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CtrlIdle,
    CtrlRun
  } ctrl_state_e;

  typedef struct packed {
    logic [PixW-1:0] left_pixel;
    logic [PixW-1:0] right_pixel;
    logic [PixW-1:0] seed_disparity;
    logic            row_start;
  } in_item_t;

  typedef struct packed {
    logic [DispW-1:0] disparity;
    logic [CostW-1:0] cost;
    logic             last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;   // take the input item into the datapath
    logic             issue;  // start a disparity this cycle
    logic [DispW-1:0] disp;   // disparity being issued
    logic             last;   // final disparity of the pixel
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             adv;        // pipeline moves this cycle
    logic [DispW-1:0] last_disp;  // effective disparity count minus one
  } ctrl_status_t;

endpackage

@@ sv/smcv_ctrl.sv @@
module smcv_ctrl import smcv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [DispW-1:0] disp_q, disp_d;

  // State and disparity counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
      disp_q  <= '0;
    end else begin
      state_q <= state_d;
      disp_q  <= disp_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    disp_d      = disp_q;
    in_stall_o  = 1'b1;
    cmd_o.load  = 1'b0;
    cmd_o.issue = 1'b0;
    cmd_o.disp  = disp_q;
    cmd_o.last  = (disp_q == status_i.last_disp);
    unique case (state_q)
      CtrlIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          disp_d     = '0;
          state_d    = CtrlRun;
        end
      end
      CtrlRun: begin
        cmd_o.issue = 1'b1;
        if (status_i.adv) begin
          if (disp_q == status_i.last_disp) begin
            state_d = CtrlIdle;
          end else begin
            disp_d = disp_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = CtrlIdle;
      end
    endcase
  end

`ifndef SYNTH
  // An accepted transaction always starts a disparity sweep
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtrlIdle && in_valid_i) |=> (state_q == CtrlRun && disp_q == '0))
    else $error("sweep did not start after accept");

  // The sweep never passes the last disparity
  a_disp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtrlRun) |-> (disp_q <= status_i.last_disp))
    else $error("disparity counter past last disparity");

  // Issuing the last disparity ends the sweep
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtrlRun && status_i.adv && disp_q == status_i.last_disp)
      |=> (state_q == CtrlIdle))
    else $error("sweep did not end after last disparity");
`endif

endmodule

@@ sv/smcv_datapath.sv @@
module smcv_datapath import smcv_pkg::*; #(
  parameter int unsigned MAX_DISP = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            in_i,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_status_t        status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output out_item_t           out_o
);

  localparam int unsigned PtrW = (MAX_DISP > 1) ? $clog2(MAX_DISP) : 1;
  localparam logic [NumW-1:0] MaxDispN = NumW'(MAX_DISP);
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(MAX_DISP - 1);
  localparam logic [PtrW:0]   DepthExt = (PtrW + 1)'(MAX_DISP);

  // Configuration registers
  logic [NumW-1:0]  num_disp_q;
  logic [GainW-1:0] data_gain_q;
  logic [CapW-1:0]  data_cap_q;
  logic [GainW-1:0] seed_gain_q;

  // Per-row state and current item
  logic [NumW-1:0]  col_q, col_d;
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PixW-1:0]  left_q, seed_q;
  logic             on_q, on_d;

  // Right pixel history, circular
  logic [PixW-1:0]  hist_mem [MAX_DISP];
  logic [PixW-1:0]  rdata_q;
  logic [PtrW-1:0]  raddr;
  logic [PtrW-1:0]  rd_disp;

  // Stage 1: history byte arrives
  logic             s1_valid_q;
  logic [DispW-1:0] s1_disp_q;
  logic             s1_last_q;
  logic [PixW-1:0]  s1_left_q, s1_seed_q;
  logic             s1_on_q;

  // Stage 2: products
  logic             s2_valid_q;
  logic [DispW-1:0] s2_disp_q;
  logic             s2_last_q;
  logic [ProdW-1:0] dprod_q, dprod_d;
  logic [ProdW-1:0] sprod_q, sprod_d;

  // Output register
  logic             out_valid_q;
  out_item_t        out_q;

  logic [NumW-1:0]  n_eff;
  logic [NumW-1:0]  x_cur;
  logic             adv;
  logic [PixW-1:0]  diff, capped, sdiff;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_disp_q  <= NumDispRst;
      data_gain_q <= DataGainRst;
      data_cap_q  <= DataCapRst;
      seed_gain_q <= SeedGainRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgNumDisp:  num_disp_q  <= cfg_data_i[NumW-1:0];
        CfgDataGain: data_gain_q <= cfg_data_i[GainW-1:0];
        CfgDataCap:  data_cap_q  <= cfg_data_i[CapW-1:0];
        CfgSeedGain: seed_gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Effective disparity count, clamped to 1..MAX_DISP
  always_comb begin
    if (num_disp_q == '0) begin
      n_eff = NumW'(1);
    end else if (num_disp_q > MaxDispN) begin
      n_eff = MaxDispN;
    end else begin
      n_eff = num_disp_q;
    end
  end

  assign adv = !(out_valid_q && out_stall_i);
  assign status_o.adv       = adv;
  assign status_o.last_disp = DispW'(n_eff - NumW'(1));

  // Column count, data enable and write pointer for a new item
  always_comb begin
    x_cur  = in_i.row_start ? '0 : col_q;
    col_d  = (x_cur != ColMax) ? x_cur + 1'b1 : x_cur;
    on_d   = (x_cur >= n_eff - NumW'(1));
    wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      wptr_q <= '0;
    end else if (cmd_i.load) begin
      col_q  <= col_d;
      wptr_q <= wptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q <= in_i.left_pixel;
      seed_q <= in_i.seed_disparity;
      on_q   <= on_d;
    end
  end

  // History address d entries back from the newest
  always_comb begin
    rd_disp = cmd_i.disp[PtrW-1:0];
    if (rd_disp <= wptr_q) begin
      raddr = wptr_q - rd_disp;
    end else begin
      raddr = PtrW'({1'b0, wptr_q} + DepthExt - {1'b0, rd_disp});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hist_mem[wptr_d] <= in_i.right_pixel;
    end
    if (adv) begin
      rdata_q <= hist_mem[raddr];
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= cmd_i.issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Truncated difference and seed distance
  always_comb begin
    diff    = (s1_left_q >= rdata_q) ? s1_left_q - rdata_q : rdata_q - s1_left_q;
    capped  = (diff > data_cap_q) ? data_cap_q : diff;
    sdiff   = (s1_seed_q >= PixW'(s1_disp_q)) ? s1_seed_q - PixW'(s1_disp_q)
                                               : PixW'(s1_disp_q) - s1_seed_q;
    dprod_d = s1_on_q ? ProdW'(data_gain_q) * ProdW'(capped) : '0;
    sprod_d = (s1_seed_q != '0) ? ProdW'(seed_gain_q) * ProdW'(sdiff) : '0;
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_disp_q <= cmd_i.disp;
      s1_last_q <= cmd_i.last;
      s1_left_q <= left_q;
      s1_seed_q <= seed_q;
      s1_on_q   <= on_q;

      s2_disp_q <= s1_disp_q;
      s2_last_q <= s1_last_q;
      dprod_q   <= dprod_d;
      sprod_q   <= sprod_d;

      out_q.disparity <= s2_disp_q;
      out_q.last      <= s2_last_q;
      out_q.cost      <= CostW'(dprod_q[ProdW-1:PixW]) + CostW'(sprod_q[ProdW-1:PixW]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  // Sum of the two truncated terms stays in range
  a_cost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.cost <= CostMax))
    else $error("cost above its largest value");

  // A stalled result transaction stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

  // The last flag marks the final disparity of the pixel
  a_last_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (out_q.disparity == status_o.last_disp))
    else $error("last flag on wrong disparity");
`endif

endmodule

@@ sv/stereo_matching_cost_volume.sv @@
// Truncated absolute-difference stereo matching cost. Each accepted input
// transaction (left pixel, right pixel, seed hint, row start) produces one
// result transaction per disparity d = 0 .. n-1, in increasing d, where n is
// num_disparities clamped to 1..MAX_DISP; the last one carries last = 1.
// cost = (data_gain * min(|L - R[x-d]|, data_cap)) >> 8, zero while the
// column is below n-1, plus (seed_gain * |seed - d|) >> 8 when seed is not 0.
// The history memory has one read port and gives one right pixel per cycle
// in a sweep while the output does not stall; a new pixel waits until the
// sweep ends. Results pass stage 1, stage 2 and the output register. Right
// pixels live in a MAX_DISP-deep circular memory that needs no clearing:
// entries are only used once the current row has written them. Configuration
// writes are always ready and must only be issued while the block is idle.
module stereo_matching_cost_volume import smcv_pkg::*; #(
  parameter int unsigned MAX_DISP = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  smcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smcv_datapath #(
    .MAX_DISP (MAX_DISP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

@@ dv/smcv_checker.sv @@
`timescale 1ns / 1ps

// Watches the config, pixel and cost channels, predicts the cost stream of
// every accepted pixel and compares each accepted cost transaction with it.
module smcv_checker import smcv_pkg::*; #(
  parameter int unsigned MAX_DISP = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_i,
  input  logic                end_check_i,
  output int                  owed_o,
  output int                  costs_seen_o,
  output int                  fail_count_o
);

  // Shadow copy of the configuration registers
  logic [NumW-1:0]  num_disp_q;
  logic [GainW-1:0] data_gain_q;
  logic [CapW-1:0]  data_cap_q;
  logic [GainW-1:0] seed_gain_q;

  // Shadow copy of the pixel state
  logic [PixW-1:0]  right_hist [MAX_DISP];
  logic [NumW-1:0]  col_cnt;

  out_item_t        cost_q [$];
  int               owed;
  int               costs_seen;
  int               fails;
  bit               end_done;

  assign owed_o       = owed;
  assign costs_seen_o = costs_seen;
  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 40) $display("[%0t ns] mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned absdiff(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Expected cost transactions of one pixel, one per disparity
  task automatic predict_costs(input in_item_t px);
    int unsigned n;
    int unsigned x;
    int unsigned diff;
    int unsigned cost;
    out_item_t   r;
    n = num_disp_q;
    if (n == 0) n = 1;
    if (n > MAX_DISP) n = MAX_DISP;
    if (px.row_start) col_cnt = '0;
    x = col_cnt;
    for (int k = MAX_DISP - 1; k > 0; k--) right_hist[k] = right_hist[k-1];
    right_hist[0] = px.right_pixel;
    for (int unsigned d = 0; d < n; d++) begin
      cost = 0;
      // data term only once the row has enough columns behind it
      if (x >= n - 1) begin
        diff = absdiff(px.left_pixel, right_hist[d]);
        if (diff > data_cap_q) diff = data_cap_q;
        cost += (data_gain_q * diff) >> 8;
      end
      if (px.seed_disparity != '0) begin
        cost += (seed_gain_q * absdiff(px.seed_disparity, d)) >> 8;
      end
      r.disparity = DispW'(d);
      r.cost      = CostW'(cost);
      r.last      = (d == n - 1);
      cost_q.push_back(r);
      owed++;
    end
    if (col_cnt < ColMax) col_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_cost;
    if (!rst_ni) begin
      num_disp_q  = NumDispRst;
      data_gain_q = DataGainRst;
      data_cap_q  = DataCapRst;
      seed_gain_q = SeedGainRst;
      for (int k = 0; k < MAX_DISP; k++) right_hist[k] = '0;
      col_cnt     = '0;
      cost_q.delete();
      owed        = 0;
      costs_seen  = 0;
      fails       = 0;
      end_done    = 1'b0;
    end else begin
      // config write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgNumDisp:  num_disp_q  = cfg_data_i[NumW-1:0];
          CfgDataGain: data_gain_q = cfg_data_i[GainW-1:0];
          CfgDataCap:  data_cap_q  = cfg_data_i[CapW-1:0];
          CfgSeedGain: seed_gain_q = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      // pixel transaction
      if (in_valid_i && !in_stall_i) predict_costs(in_i);
      // cost transaction
      if (out_valid_i && !out_stall_i) begin
        costs_seen++;
        if (cost_q.size() == 0) begin
          report_mismatch($sformatf("unexpected cost: disp=%0d cost=%0d last=%0d",
                                    out_i.disparity, out_i.cost, out_i.last));
        end else begin
          exp_cost = cost_q.pop_front();
          owed--;
          if (out_i.disparity !== exp_cost.disparity)
            report_mismatch($sformatf("disparity %0d, expected %0d",
                                      out_i.disparity, exp_cost.disparity));
          if (out_i.cost !== exp_cost.cost)
            report_mismatch($sformatf("cost %0d at disp %0d, expected %0d",
                                      out_i.cost, exp_cost.disparity, exp_cost.cost));
          if (out_i.last !== exp_cost.last)
            report_mismatch($sformatf("last %0d at disp %0d, expected %0d",
                                      out_i.last, exp_cost.disparity, exp_cost.last));
        end
      end
      // leftovers at the end of the run
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (cost_q.size() != 0)
          report_mismatch($sformatf("%0d cost transactions never arrived", cost_q.size()));
      end
    end
  end

endmodule

@@ dv/tb_stereo_matching_cost_volume.sv @@
`timescale 1ns / 1ps

module tb_stereo_matching_cost_volume;
  import smcv_pkg::*;

  localparam int unsigned MaxDisp     = 64;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned SettleWait  = 16;

  bit                  clk_i;
  logic                rst_ni;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                end_check;

  int                  owed;
  int                  costs_seen;
  int                  fails;
  int                  pixels_sent;
  int                  settings;
  int unsigned         idle_cycles;

  // sink and source control
  bit                  sink_calm;
  bit                  src_calm;
  bit                  hold_req;
  bit                  hold_done;

  stereo_matching_cost_volume #(
    .MAX_DISP(MaxDisp)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  smcv_checker #(
    .MAX_DISP(MaxDisp)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_data),
    .end_check_i  (end_check),
    .owed_o       (owed),
    .costs_seen_o (costs_seen),
    .fail_count_o (fails)
  );

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no transaction for %0d cycles", IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Cost receiver: random stalls, a calm stretch and one long hold-off
  initial begin : sink
    int unsigned hold_cnt;
    hold_cnt  = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt == HoldCycles) hold_done = 1'b1;
      end else if (sink_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 21);
      end
    end
  end

  function automatic in_item_t mk_pixel(input logic rs, input logic [PixW-1:0] l,
                                        input logic [PixW-1:0] r,
                                        input logic [PixW-1:0] s);
    in_item_t px;
    px.left_pixel     = l;
    px.right_pixel    = r;
    px.seed_disparity = s;
    px.row_start      = rs;
    return px;
  endfunction

  function automatic logic [PixW-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(255));
    endcase
  endfunction

  // Seed hints: often none, often near the disparity range, sometimes anywhere
  function automatic logic [PixW-1:0] pick_seed(input int unsigned neff);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return '0;
    if (r < 80) return PixW'($urandom_range(neff + 2, 1));
    return PixW'($urandom_range(255, 1));
  endfunction

  // Offer one pixel transaction, hold it until taken; returns at a falling edge
  task automatic send_pixel(input in_item_t px);
    while (!src_calm && ($urandom_range(99) < 21)) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all four registers; only called while the block is idle
  task automatic program_regs(input logic [CfgDataW-1:0] num_word,
                              input logic [CfgDataW-1:0] gain_word,
                              input logic [CfgDataW-1:0] cap_word,
                              input logic [CfgDataW-1:0] seed_word);
    write_reg(CfgNumDisp, num_word);
    write_reg(CfgDataGain, gain_word);
    write_reg(CfgDataCap, cap_word);
    write_reg(CfgSeedGain, seed_word);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Sender pauses until every expected cost transaction has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk_i);
  endtask

  // Rows of random pixels; most rows long enough to enable the data term,
  // some short, and a few with a stray or dropped row start
  task automatic send_random(input int unsigned count, input int unsigned neff,
                             input bit one_row);
    int unsigned row_left;
    bit          at_head;
    in_item_t    px;
    row_left = 0;
    at_head  = 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      if (row_left == 0) begin
        if (one_row) row_left = count;
        else if ($urandom_range(99) < 85) row_left = $urandom_range(neff + 8, neff);
        else row_left = $urandom_range(neff, 1);
        at_head = 1'b1;
      end
      px.left_pixel     = pick_level();
      px.right_pixel    = pick_level();
      px.seed_disparity = pick_seed(neff);
      px.row_start      = at_head;
      if (!one_row && ($urandom_range(99) < 8)) px.row_start = ~px.row_start;
      send_pixel(px);
      at_head = 1'b0;
      row_left--;
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned neff;
    rst_ni      = 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CfgNumDisp;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    end_check  <= 1'b0;
    pixels_sent = 0;
    settings    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: 64 disparities, no seed weight
    send_pixel(mk_pixel(1'b1, 8'd255, 8'd0, 8'd0));
    send_pixel(mk_pixel(1'b0, 8'd0, 8'd255, 8'd63));
    send_pixel(mk_pixel(1'b0, 8'd200, 8'd100, 8'd1));
    wait_drained();

    // Directed: three disparities, full gains, largest cost, row restarts
    program_regs(16'h0003, 16'hFFFF, 16'h00FF, 16'hFFFF);
    send_pixel(mk_pixel(1'b1, 8'd0, 8'd255, 8'd0));
    send_pixel(mk_pixel(1'b0, 8'd255, 8'd0, 8'd1));
    send_pixel(mk_pixel(1'b0, 8'd0, 8'd255, 8'd255));
    send_pixel(mk_pixel(1'b0, 8'd255, 8'd0, 8'd2));
    send_pixel(mk_pixel(1'b0, 8'd128, 8'd128, 8'd3));
    send_pixel(mk_pixel(1'b0, 8'd255, 8'd255, 8'd0));
    send_pixel(mk_pixel(1'b0, 8'd1, 8'd254, 8'd64));
    send_pixel(mk_pixel(1'b1, 8'd17, 8'd200, 8'd0));
    send_pixel(mk_pixel(1'b0, 8'd200, 8'd17, 8'd1));
    send_pixel(mk_pixel(1'b1, 8'd5, 8'd5, 8'd0));
    send_pixel(mk_pixel(1'b1, 8'd90, 8'd30, 8'd2));
    send_pixel(mk_pixel(1'b0, 8'd30, 8'd90, 8'd0));
    send_pixel(mk_pixel(1'b0, 8'd255, 8'd0, 8'd255));
    send_pixel(mk_pixel(1'b0, 8'd0, 8'd0, 8'd0));
    wait_drained();

    // Small disparity count, random weights; junk in the unused data bits
    neff = $urandom_range(8, 2);
    program_regs({9'($urandom), 7'(neff)}, 16'($urandom), 16'($urandom),
                 16'($urandom));
    send_random(20, neff, 1'b0);
    wait_drained();
    sink_calm = 1'b1;
    send_random(20, neff, 1'b0);
    wait_drained();
    sink_calm = 1'b0;

    // Count of zero taken as one, cap of zero kills the data term
    program_regs(16'hFF80, 16'hFFFF, 16'hAB00, 16'h0001);
    send_random(20, 1, 1'b0);
    wait_drained();

    // Count above the maximum, one long row that saturates the column count;
    // the receiver holds off while the sender keeps offering
    program_regs({9'($urandom), 7'd127}, 16'($urandom), 16'($urandom),
                 16'($urandom));
    src_calm = 1'b1;
    hold_req = 1'b1;
    send_random(130, MaxDisp, 1'b0 | 1'b1);
    wait_drained();
    src_calm = 1'b0;

    // Just over the maximum, zero data gain, full seed weight
    program_regs(16'h0041, 16'h0000, 16'($urandom), 16'hFFFF);
    send_random(15, MaxDisp, 1'b0);
    wait_drained();

    repeat (SettleWait) @(negedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(negedge clk_i);

    $display("Covered %0d pixels over %0d register settings, %0d costs compared.",
             pixels_sent, settings + 1, costs_seen);
    $display("Included clamped counts, column saturation and a %0d-cycle output hold-off.",
             HoldCycles);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fails);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
